@@ rtl/sitrs_pkg.sv @@
`default_nettype none

package sitrs_pkg;

  localparam int unsigned PeriodWidth  = 28;
  localparam int unsigned ElapsedWidth = 20;
  localparam int unsigned IdWidth      = 3;
  localparam int unsigned NumTables    = 6;
  localparam int unsigned AddrWidth    = 4;
  localparam int unsigned DataWidth    = 32;
  localparam int unsigned CountWidth   = 30;

  localparam logic [PeriodWidth-1:0] FastPeriodReset = 28'd2700000;
  localparam logic [PeriodWidth-1:0] SlowPeriodReset = 28'd27000000;
  localparam logic [PeriodWidth-1:0] TimePeriodReset = 28'd243000000;

  localparam logic [NumTables-1:0] MarkFast = 6'b000101;
  localparam logic [NumTables-1:0] MarkSlow = 6'b111000;
  localparam logic [NumTables-1:0] MarkTime = 6'b000010;

  typedef enum logic [1:0] {
    REG_FAST_PERIOD = 2'd0,
    REG_SLOW_PERIOD = 2'd1,
    REG_TIME_PERIOD = 2'd2
  } reg_index_t;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_WORK = 1'b1
  } kind_t;

  typedef struct packed {
    logic                    kind;
    logic [ElapsedWidth-1:0] elapsed_ticks;
  } in_word_t;

  typedef struct packed {
    logic [IdWidth-1:0] table_id;
    logic               last;
  } out_word_t;

endpackage

`default_nettype wire

@@ rtl/si_table_repetition_scheduler.sv @@
// Channel  Dir  Handshake           Word
// in       in   in_valid/in_ready   sitrs_pkg::in_word_t  (kind, elapsed_ticks)
// out      out  out_valid/out_ready sitrs_pkg::out_word_t (table_id, last)
// cfg      in   APB psel/penable    fast, slow, time period at 0x0, 0x4, 0x8
//
// A tick word is taken every cycle and updates all three timers together.
// A work word moves the pending marks into the emit register; one table id
// leaves per cycle while out_ready is high; a work word sends zero to six ids.
// A work word is taken once the emit register is empty or sends its last id;
// tick words are taken while ids are still leaving.
// Synchronous reset loads the default periods and clears counts and marks.
`default_nettype none

module si_table_repetition_scheduler #(
  parameter int unsigned COUNT_WIDTH = sitrs_pkg::CountWidth
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire sitrs_pkg::in_word_t             in_data,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      sitrs_pkg::out_word_t            out_data,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [sitrs_pkg::AddrWidth-1:0] paddr,
  input  wire logic [sitrs_pkg::DataWidth-1:0] pwdata,
  output      logic [sitrs_pkg::DataWidth-1:0] prdata,
  output      logic                            pready
);

  logic [sitrs_pkg::PeriodWidth-1:0] fast_period;
  logic [sitrs_pkg::PeriodWidth-1:0] slow_period;
  logic [sitrs_pkg::PeriodWidth-1:0] time_period;

  logic [COUNT_WIDTH-1:0] fast_count, fast_count_next;
  logic [COUNT_WIDTH-1:0] slow_count, slow_count_next;
  logic [COUNT_WIDTH-1:0] time_count, time_count_next;

  logic [sitrs_pkg::NumTables-1:0] pending_marks, pending_marks_next;
  logic [sitrs_pkg::NumTables-1:0] emit_marks, emit_marks_next;

  logic                    cfg_write;
  logic [1:0]              cfg_index;
  logic [COUNT_WIDTH-1:0]  elapsed;
  logic                    in_accept;
  logic                    out_accept;
  logic                    emit_done;
  logic [COUNT_WIDTH-1:0]  fast_diff, slow_diff, time_diff;
  logic                    fast_fire, slow_fire, time_fire;
  logic [sitrs_pkg::IdWidth-1:0] first_id;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[3:2];

  always_comb begin
    case (sitrs_pkg::reg_index_t'(cfg_index))
      sitrs_pkg::REG_FAST_PERIOD: prdata = sitrs_pkg::DataWidth'(fast_period);
      sitrs_pkg::REG_SLOW_PERIOD: prdata = sitrs_pkg::DataWidth'(slow_period);
      sitrs_pkg::REG_TIME_PERIOD: prdata = sitrs_pkg::DataWidth'(time_period);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_period <= sitrs_pkg::FastPeriodReset;
      slow_period <= sitrs_pkg::SlowPeriodReset;
      time_period <= sitrs_pkg::TimePeriodReset;
    end else if (cfg_write) begin
      case (sitrs_pkg::reg_index_t'(cfg_index))
        sitrs_pkg::REG_FAST_PERIOD: fast_period <= pwdata[sitrs_pkg::PeriodWidth-1:0];
        sitrs_pkg::REG_SLOW_PERIOD: slow_period <= pwdata[sitrs_pkg::PeriodWidth-1:0];
        sitrs_pkg::REG_TIME_PERIOD: time_period <= pwdata[sitrs_pkg::PeriodWidth-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid  = |emit_marks;
  assign emit_done  = (emit_marks == '0) || (out_ready && $onehot(emit_marks));
  assign in_ready   = emit_done || (in_data.kind == sitrs_pkg::KIND_TICK);
  assign in_accept  = in_valid && in_ready;
  assign out_accept = out_valid && out_ready;

  always_comb begin
    first_id = '0;
    for (int i = sitrs_pkg::NumTables - 1; i >= 0; i--) begin
      if (emit_marks[i]) begin
        first_id = sitrs_pkg::IdWidth'(i);
      end
    end
  end

  assign out_data.table_id = first_id;
  assign out_data.last     = $onehot(emit_marks);

  assign elapsed   = COUNT_WIDTH'(in_data.elapsed_ticks);
  assign fast_diff = fast_count - elapsed;
  assign slow_diff = slow_count - elapsed;
  assign time_diff = time_count - elapsed;
  assign fast_fire = (fast_diff == '0) || fast_diff[COUNT_WIDTH-1];
  assign slow_fire = (slow_diff == '0) || slow_diff[COUNT_WIDTH-1];
  assign time_fire = (time_diff == '0) || time_diff[COUNT_WIDTH-1];

  always_comb begin
    fast_count_next    = fast_count;
    slow_count_next    = slow_count;
    time_count_next    = time_count;
    pending_marks_next = pending_marks;
    emit_marks_next    = emit_marks;
    if (out_accept) begin
      emit_marks_next = emit_marks & (emit_marks - sitrs_pkg::NumTables'(1));
    end
    if (in_accept) begin
      if (in_data.kind == sitrs_pkg::KIND_TICK) begin
        fast_count_next = fast_fire ? COUNT_WIDTH'(fast_period) : fast_diff;
        slow_count_next = slow_fire ? COUNT_WIDTH'(slow_period) : slow_diff;
        time_count_next = time_fire ? COUNT_WIDTH'(time_period) : time_diff;
        pending_marks_next = pending_marks
                           | (fast_fire ? sitrs_pkg::MarkFast : '0)
                           | (slow_fire ? sitrs_pkg::MarkSlow : '0)
                           | (time_fire ? sitrs_pkg::MarkTime : '0);
      end else begin
        emit_marks_next    = pending_marks;
        pending_marks_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_count    <= '0;
      slow_count    <= '0;
      time_count    <= '0;
      pending_marks <= '0;
      emit_marks    <= '0;
    end else begin
      fast_count    <= fast_count_next;
      slow_count    <= slow_count_next;
      time_count    <= time_count_next;
      pending_marks <= pending_marks_next;
      emit_marks    <= emit_marks_next;
    end
  end

`ifndef SYNTHESIS
  a_work_clears_marks: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_data.kind == sitrs_pkg::KIND_WORK) |=> (pending_marks == '0))
    else $error("pending marks not cleared after work word");

  a_work_loads_emit: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_data.kind == sitrs_pkg::KIND_WORK)
      |=> (emit_marks == $past(pending_marks)))
    else $error("emit register does not hold the pending marks");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (out_accept && !out_data.last && !in_accept) |=> out_valid)
    else $error("table burst ended before last");

  a_tick_keeps_emit: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_data.kind == sitrs_pkg::KIND_TICK && !out_accept)
      |=> $stable(emit_marks))
    else $error("tick word disturbed the emit register");
`endif

endmodule

`default_nettype wire
